// ===== src/csf_pkg.sv =====
// ---------------------------------------------------------------------------
// Conservative smoothing filter package
// Shared types and register index codes of the filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csf_pkg;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WINDOW_SIZE  = 3'd2;
  localparam logic [2:0] REG_AREA_LEFT    = 3'd3;
  localparam logic [2:0] REG_AREA_TOP     = 3'd4;
  localparam logic [2:0] REG_AREA_WIDTH   = 3'd5;
  localparam logic [2:0] REG_AREA_HEIGHT  = 3'd6;

  localparam int CFG_DATA_BITS = 11;

  typedef struct packed {
    logic clr;
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/csf_cell.sv =====
// ---------------------------------------------------------------------------
// Conservative smoothing filter cell
// Keeps the running minimum and maximum of one window row and merges the
// result of its left neighbor during the reduction pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csf_cell
  import csf_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cell_ctl_t                     ctl,
  input  wire logic                          sel,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          left_found,
  input  wire logic signed [SAMPLE_BITS-1:0] left_mn,
  input  wire logic signed [SAMPLE_BITS-1:0] left_mx,
  output logic                               found,
  output logic signed [SAMPLE_BITS-1:0]      mn,
  output logic signed [SAMPLE_BITS-1:0]      mx
);

  logic                          found_r;
  logic                          found_nxt;
  logic signed [SAMPLE_BITS-1:0] mn_r;
  logic signed [SAMPLE_BITS-1:0] mn_nxt;
  logic signed [SAMPLE_BITS-1:0] mx_r;
  logic signed [SAMPLE_BITS-1:0] mx_nxt;

  always_comb begin
    found_nxt = found_r;
    mn_nxt    = mn_r;
    mx_nxt    = mx_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
    end else if (ctl.load && sel) begin
      found_nxt = 1'b1;
      mn_nxt    = (!found_r || sample < mn_r) ? sample : mn_r;
      mx_nxt    = (!found_r || sample > mx_r) ? sample : mx_r;
    end else if (ctl.shift && left_found) begin
      found_nxt = 1'b1;
      mn_nxt    = (!found_r || left_mn < mn_r) ? left_mn : mn_r;
      mx_nxt    = (!found_r || left_mx > mx_r) ? left_mx : mx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    mn_r <= mn_nxt;
    mx_r <= mx_nxt;
  end

  assign found = found_r;
  assign mn    = mn_r;
  assign mx    = mx_r;

endmodule

`default_nettype wire

// ===== src/conservative_smoothing_filter_unit.sv =====
// An item without a result is taken in ST_IDLE alone; one with a result visits
// ST_CENTER, ST_DRAIN and ST_OUT, and inside the filtered area also ST_SCAN
// and ST_RED. ST_SCAN reads the s by s window (s being the window size) through
// the single line memory read port, one neighbor per cycle; ST_RED is the
// reduction pass along the cell chain. Inputs are taken only in ST_IDLE with a
// free result slot. Synchronous active-low reset clears the counters and
// control, not the line memory.
// Conservative smoothing filter unit
// Line memory, scan sequencer and a chain of min/max cells per window row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module conservative_smoothing_filter_unit
  import csf_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int MAX_WINDOW  = 9,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [SAMPLE_BITS-1:0] sample_value, zero padded to bytes
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // [0] command
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [SAMPLE_BITS-1:0] filtered_value, zero padded to bytes
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]   out_tdata,
  output logic                               out_tlast,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int DB   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int WB   = $clog2(MAX_WIDTH + 1);
  localparam int HB   = $clog2(MAX_HEIGHT + 1);
  localparam int CB   = $clog2(MAX_WIDTH);
  localparam int RB   = $clog2(MAX_HEIGHT);
  localparam int SWB  = $clog2(MAX_WINDOW + 1);
  localparam int TGB  = $clog2(MAX_WINDOW);
  localparam int TB   = WB + HB;
  localparam int KB   = TB + 1;
  localparam int DLB  = WB + SWB;
  localparam int AB   = TGB + CB;
  localparam int MEM_DEPTH = MAX_WINDOW << CB;
  localparam int RCB  = $clog2(MAX_WINDOW);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CENTER = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_RED    = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  // Configuration registers.
  logic [10:0] frame_width_r, frame_height_r, area_width_r, area_height_r;
  logic [3:0]  window_size_r;
  logic [9:0]  area_left_r, area_top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 11'd1024;
      frame_height_r <= 11'd1024;
      window_size_r  <= 4'd3;
      area_left_r    <= 10'd0;
      area_top_r     <= 10'd0;
      area_width_r   <= 11'd1024;
      area_height_r  <= 11'd1024;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[10:0];
        REG_WINDOW_SIZE:  window_size_r  <= cfg_data[3:0];
        REG_AREA_LEFT:    area_left_r    <= cfg_data[9:0];
        REG_AREA_TOP:     area_top_r     <= cfg_data[9:0];
        REG_AREA_WIDTH:   area_width_r   <= cfg_data[10:0];
        REG_AREA_HEIGHT:  area_height_r  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Derived frame geometry.
  logic [31:0]    fw32, fh32, ws32, al32, at32, aw32, ah32;
  logic [WB-1:0]  w_r, w_nxt;
  logic [HB-1:0]  h_r, h_nxt;
  logic [SWB-1:0] s_r, s_nxt, lo_r, lo_nxt, a_nxt;
  logic [TB-1:0]  total_r, total_nxt;
  logic [DLB-1:0] delay_r, delay_nxt;
  logic           area_ok_r, area_ok_nxt;
  logic [11:0]    top_r, bot_r, left_r, right_r;

  always_comb begin
    fw32 = 32'(frame_width_r);
    fh32 = 32'(frame_height_r);
    ws32 = 32'(window_size_r);
    al32 = 32'(area_left_r);
    at32 = 32'(area_top_r);
    aw32 = 32'(area_width_r);
    ah32 = 32'(area_height_r);
    w_nxt = (fw32 == 32'd0) ? WB'(1) :
            (fw32 > 32'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : WB'(fw32);
    h_nxt = (fh32 == 32'd0) ? HB'(1) :
            (fh32 > 32'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT) : HB'(fh32);
    s_nxt = (ws32 < 32'd2) ? SWB'(2) :
            (ws32 > 32'(MAX_WINDOW)) ? SWB'(MAX_WINDOW) : SWB'(ws32);
    lo_nxt    = s_nxt >> 1;
    a_nxt     = s_nxt - lo_nxt - SWB'(1);
    total_nxt = TB'(w_nxt) * TB'(h_nxt);
    delay_nxt = DLB'(a_nxt) * (DLB'(w_nxt) + DLB'(1));
    area_ok_nxt = (al32 + aw32 <= 32'(w_nxt)) && (at32 + ah32 <= 32'(h_nxt)) &&
                  (aw32 >= 32'(s_nxt)) && (ah32 >= 32'(s_nxt));
  end

  always_ff @(posedge clk) begin
    w_r       <= w_nxt;
    h_r       <= h_nxt;
    s_r       <= s_nxt;
    lo_r      <= lo_nxt;
    total_r   <= total_nxt;
    delay_r   <= delay_nxt;
    area_ok_r <= area_ok_nxt;
    top_r     <= 12'(area_top_r);
    bot_r     <= 12'(area_top_r) + 12'(area_height_r);
    left_r    <= 12'(area_left_r);
    right_r   <= 12'(area_left_r) + 12'(area_width_r);
  end

  // Control state.
  logic [2:0]     state_r, state_nxt;
  logic [KB-1:0]  k_r, k_nxt;
  logic [TB-1:0]  p_r, p_nxt;
  logic [CB-1:0]  wcol_r, wcol_nxt, rcol_r, rcol_nxt;
  logic [RCB-1:0] wrm_r, wrm_nxt, rrm_r, rrm_nxt;
  logic [RB-1:0]  rrow_r, rrow_nxt;
  logic [TGB-1:0] mi_r, mi_nxt, ni_r, ni_nxt;
  logic [TGB-1:0] red_r, red_nxt;
  logic           active_r, active_nxt;
  logic           out_tvalid_r, out_tvalid_nxt;
  logic [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;
  logic           out_last_r, out_last_nxt;

  logic                   mem_we, mem_re, rd_ctr, rd_vld_r, rd_ctr_r;
  logic [AB-1:0]          mem_wa, mem_ra;
  logic [SAMPLE_BITS-1:0] mem_wd, mem_q_r;
  logic [TGB-1:0]         rd_tag, rd_tag_r;
  logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
  logic signed [SAMPLE_BITS-1:0] center_r;

  logic                 accept, restart;
  logic [KB-1:0]        k_e;
  logic [CB-1:0]        wcol_e;
  logic [RCB-1:0]       wrm_e;
  logic signed [RB+2:0] rr;
  logic signed [CB+2:0] cc;
  logic signed [7:0]    rm_t;
  logic [RCB-1:0]       rm;
  logic                 last_pix;
  logic signed [SAMPLE_BITS-1:0] v;

  cell_ctl_t ctl;
  logic                          c_found [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] c_mn [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] c_mx [MAX_WINDOW];

  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE) && (!out_tvalid_r || out_tready);

  always_comb begin
    restart = (p_r >= total_r) || (k_r >= KB'(total_r) + KB'(delay_r));
    k_e     = restart ? '0 : k_r;
    wcol_e  = restart ? '0 : wcol_r;
    wrm_e   = restart ? '0 : wrm_r;

    rr   = $signed((RB+3)'(rrow_r)) + $signed((RB+3)'(mi_r)) - $signed((RB+3)'(lo_r));
    cc   = $signed((CB+3)'(rcol_r)) + $signed((CB+3)'(ni_r)) - $signed((CB+3)'(lo_r));
    rm_t = $signed(8'(rrm_r)) + $signed(8'(mi_r)) - $signed(8'(lo_r));
    if (rm_t < 0) begin
      rm = RCB'(rm_t + 8'sd0 + 8'(MAX_WINDOW));
    end else if (rm_t >= $signed(8'(MAX_WINDOW))) begin
      rm = RCB'(rm_t - $signed(8'(MAX_WINDOW)));
    end else begin
      rm = RCB'(rm_t);
    end

    last_pix = (p_r + TB'(1)) == total_r;
    v = center_r;
    if (active_r && c_found[MAX_WINDOW-1]) begin
      if (center_r > c_mx[MAX_WINDOW-1]) begin
        v = c_mx[MAX_WINDOW-1];
      end else if (center_r < c_mn[MAX_WINDOW-1]) begin
        v = c_mn[MAX_WINDOW-1];
      end
    end

    state_nxt      = state_r;
    k_nxt          = k_r;
    p_nxt          = p_r;
    wcol_nxt       = wcol_r;
    wrm_nxt        = wrm_r;
    rcol_nxt       = rcol_r;
    rrow_nxt       = rrow_r;
    rrm_nxt        = rrm_r;
    mi_nxt         = mi_r;
    ni_nxt         = ni_r;
    red_nxt        = red_r;
    active_nxt     = active_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    mem_we = 1'b0;
    mem_wa = {wrm_e, wcol_e};
    mem_wd = in_tuser ? '0 : in_tdata[SAMPLE_BITS-1:0];
    mem_re = 1'b0;
    mem_ra = {rrm_r, rcol_r};
    rd_ctr = 1'b0;
    rd_tag = mi_r;
    ctl    = '{clr: 1'b0, load: rd_vld_r && !rd_ctr_r, shift: 1'b0};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (restart) begin
            p_nxt    = '0;
            rcol_nxt = '0;
            rrow_nxt = '0;
            rrm_nxt  = '0;
          end
          if (k_e < KB'(total_r)) begin
            mem_we = 1'b1;
            if (32'(wcol_e) + 32'd1 == 32'(w_r)) begin
              wcol_nxt = '0;
              wrm_nxt  = (32'(wrm_e) == 32'(MAX_WINDOW - 1)) ? '0 : wrm_e + RCB'(1);
            end else begin
              wcol_nxt = wcol_e + CB'(1);
              wrm_nxt  = wrm_e;
            end
          end else begin
            wcol_nxt = wcol_e;
            wrm_nxt  = wrm_e;
          end
          k_nxt = k_e + KB'(1);
          if (k_e >= KB'(delay_r)) begin
            state_nxt = ST_CENTER;
          end
        end
      end
      ST_CENTER: begin
        mem_re     = 1'b1;
        rd_ctr     = 1'b1;
        ctl.clr    = 1'b1;
        mi_nxt     = '0;
        ni_nxt     = '0;
        active_nxt = area_ok_r &&
                     32'(rrow_r) >= 32'(top_r) && 32'(rrow_r) < 32'(bot_r) &&
                     32'(rcol_r) >= 32'(left_r) && 32'(rcol_r) < 32'(right_r);
        state_nxt  = active_nxt ? ST_SCAN : ST_DRAIN;
      end
      ST_SCAN: begin
        mem_ra = {rm, cc[CB-1:0]};
        mem_re = (rr >= 0) && (rr < $signed((RB+3)'(h_r))) &&
                 (cc >= 0) && (cc < $signed((CB+3)'(w_r))) &&
                 !(mi_r == TGB'(lo_r) && ni_r == TGB'(lo_r));
        if (32'(ni_r) + 32'd1 == 32'(s_r)) begin
          ni_nxt = '0;
          mi_nxt = mi_r + TGB'(1);
          if (32'(mi_r) + 32'd1 == 32'(s_r)) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          ni_nxt = ni_r + TGB'(1);
        end
      end
      ST_DRAIN: begin
        red_nxt   = '0;
        state_nxt = active_r ? ST_RED : ST_OUT;
      end
      ST_RED: begin
        ctl.shift = 1'b1;
        red_nxt   = red_r + TGB'(1);
        if (32'(red_r) + 32'd2 >= 32'(MAX_WINDOW)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_tvalid_nxt = 1'b1;
        out_data_nxt   = v;
        out_last_nxt   = last_pix;
        state_nxt      = ST_IDLE;
        p_nxt          = p_r + TB'(1);
        if (32'(rcol_r) + 32'd1 == 32'(w_r)) begin
          rcol_nxt = '0;
          rrow_nxt = rrow_r + RB'(1);
          rrm_nxt  = (32'(rrm_r) == 32'(MAX_WINDOW - 1)) ? '0 : rrm_r + RCB'(1);
        end else begin
          rcol_nxt = rcol_r + CB'(1);
        end
        if (last_pix) begin
          k_nxt    = '0;
          p_nxt    = '0;
          wcol_nxt = '0;
          wrm_nxt  = '0;
          rcol_nxt = '0;
          rrow_nxt = '0;
          rrm_nxt  = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      k_r          <= '0;
      p_r          <= '0;
      wcol_r       <= '0;
      wrm_r        <= '0;
      rcol_r       <= '0;
      rrow_r       <= '0;
      rrm_r        <= '0;
      mi_r         <= '0;
      ni_r         <= '0;
      red_r        <= '0;
      active_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      rd_ctr_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      p_r          <= p_nxt;
      wcol_r       <= wcol_nxt;
      wrm_r        <= wrm_nxt;
      rcol_r       <= rcol_nxt;
      rrow_r       <= rrow_nxt;
      rrm_r        <= rrm_nxt;
      mi_r         <= mi_nxt;
      ni_r         <= ni_nxt;
      red_r        <= red_nxt;
      active_r     <= active_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      rd_vld_r     <= mem_re;
      rd_ctr_r     <= rd_ctr;
    end
    rd_tag_r   <= rd_tag;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (rd_vld_r && rd_ctr_r) begin
      center_r <= mem_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_ra];
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                          lf;
    logic signed [SAMPLE_BITS-1:0] lmn, lmx;
    if (i == 0) begin : g_first
      assign lf  = 1'b0;
      assign lmn = '0;
      assign lmx = '0;
    end else begin : g_rest
      assign lf  = c_found[i-1];
      assign lmn = c_mn[i-1];
      assign lmx = c_mx[i-1];
    end
    csf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .sel        (rd_tag_r == TGB'(i)),
      .sample     (mem_q_r),
      .left_found (lf),
      .left_mn    (lmn),
      .left_mx    (lmx),
      .found      (c_found[i]),
      .mn         (c_mn[i]),
      .mx         (c_mx[i])
    );
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DB'(out_data_r);
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== src/csf_checker.sv =====
// ---------------------------------------------------------------------------
// Conservative smoothing filter checker
// Port-level properties of the filter unit, attached by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csf_checker #(
  parameter int DB = 16
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_tready,
  input wire logic          out_tvalid,
  input wire logic          out_tready,
  input wire logic [DB-1:0] out_tdata,
  input wire logic          out_tlast
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result valid right after reset.");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Stalled result dropped.");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("Stalled result changed.");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("Input taken while the result slot is blocked.");

endmodule

bind conservative_smoothing_filter_unit csf_checker #(
  .DB(((SAMPLE_BITS + 7) / 8) * 8)
) u_csf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
